// ===== rtl/rpd_pkg.sv =====
package rpd_pkg;

	localparam int SHORT_PACKET_BYTES = 6;

	localparam logic [7:0] SYNC_SHORT = 8'h6B;
	localparam logic [7:0] SYNC_LONG  = 8'h6F;
	localparam logic [7:0] PRESS_CHAR = 8'h31;
	localparam logic [7:0] PORT_MASK  = 8'h0F;
	localparam logic [7:0] KEY_MASK   = 8'hE0;
	localparam int         KEY_SHIFT  = 5;

	localparam logic       CMD_BYTE  = 1'b0;
	localparam logic       CMD_CLEAR = 1'b1;

	localparam logic [1:0] REG_PACKET_MODE   = 2'd0;
	localparam logic [1:0] REG_BAD_PORT_MASK = 2'd1;
	localparam logic [1:0] REG_PRESS_MASK    = 2'd2;

	typedef struct packed {
		logic [7:0]  port_number;
		logic [7:0]  key_number;
		logic        pressed;
		logic [31:0] reaction_time;
	} event_t;

endpackage

// ===== rtl/response_packet_deframer.sv =====
// channel  | valid     | stall     | payload
// ---------+-----------+-----------+------------------------------------------------
// input    | in_valid  | in_stall  | cmd, rx_byte
// output   | out_valid | out_stall | port_number, key_number, pressed,
//          |           |           | reaction_time, keys_down
// config   | cfg_we    | -         | cfg_index, cfg_data
//
// One item per cycle while in_stall is low. An item is held in the input register
// until it advances; the packet buffer is then updated and any result lands in
// the output register.
// Reset empties the packet buffer, zeroes the keys-down count and loads the
// register defaults (short mode, bad_port_mask 0, press_mask 0x10).
// in_stall rises only while an item waits in the input register and the output
// register holds a result that is stalled.
module response_packet_deframer
	import rpd_pkg::*;
#(
	parameter int LONG_PACKET_BYTES = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  port_number,
	output logic [7:0]  key_number,
	output logic        pressed,
	output logic [31:0] reaction_time,
	output logic [7:0]  keys_down,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	localparam int FW = $clog2(LONG_PACKET_BYTES + 1);
	localparam int IW = $clog2(LONG_PACKET_BYTES);

	logic             packet_mode_q;
	logic [7:0]       bad_port_mask_q;
	logic [7:0]       press_mask_q;

	logic [7:0]       buf_q [LONG_PACKET_BYTES];
	logic [FW-1:0]    fill_q;
	logic [7:0]       down_q;

	logic             valid_s1;
	logic             cmd_s1;
	logic [7:0]       byte_s1;

	logic             out_valid_q;
	event_t           evt_q;
	logic [7:0]       keys_down_q;

	logic             advance;
	logic [7:0]       nb [LONG_PACKET_BYTES];
	logic [7:0]       sb [LONG_PACKET_BYTES];
	logic [FW-1:0]    nf;
	logic [FW-1:0]    nf_shift;
	logic [FW-1:0]    size;
	logic [IW-1:0]    pos;
	logic [7:0]       sync;
	logic             hdr_ok;
	logic             found;
	logic             flush;
	event_t           evt;
	logic [7:0]       down_next;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_comb begin
		size = packet_mode_q ? FW'(LONG_PACKET_BYTES) : FW'(SHORT_PACKET_BYTES);
		sync = packet_mode_q ? SYNC_LONG : SYNC_SHORT;
		nf   = fill_q + FW'(1);

		// drop the new byte in at the fill point
		for (int i = 0; i < LONG_PACKET_BYTES; i++) begin
			nb[i] = (fill_q == FW'(i)) ? byte_s1 : buf_q[i];
		end

		if (packet_mode_q) begin
			hdr_ok = (nf == FW'(LONG_PACKET_BYTES)) && (nb[0] == SYNC_LONG)
				&& (nb[LONG_PACKET_BYTES-1] == 8'h00);
			found  = hdr_ok;
		end else begin
			hdr_ok = (nb[0] == SYNC_SHORT) && ((nb[1] & bad_port_mask_q) == 8'h00);
			found  = hdr_ok && (nf == FW'(SHORT_PACKET_BYTES));
		end

		// first later sync letter, searched from the top so the lowest wins
		pos = '0;
		if (!hdr_ok) begin
			for (int i = LONG_PACKET_BYTES - 1; i >= 1; i--) begin
				if ((nb[i] == sync) && (FW'(i) < nf)
						&& (packet_mode_q || (i < SHORT_PACKET_BYTES))) begin
					pos = IW'(i);
				end
			end
		end

		for (int i = 0; i < LONG_PACKET_BYTES; i++) begin
			sb[i] = 8'h00;
			for (int p = 0; p < LONG_PACKET_BYTES - i; p++) begin
				if (pos == IW'(p)) begin
					sb[i] = nb[i+p];
				end
			end
		end
		nf_shift = nf - FW'(pos);
		flush    = (nf_shift >= size);

		if (packet_mode_q) begin
			evt.port_number   = nb[1];
			evt.key_number    = nb[2];
			evt.pressed       = (nb[3] == PRESS_CHAR);
			evt.reaction_time = {nb[7], nb[6], nb[5], nb[4]};
		end else begin
			evt.port_number   = nb[1] & PORT_MASK;
			evt.key_number    = (nb[1] & KEY_MASK) >> KEY_SHIFT;
			evt.pressed       = ((nb[1] & press_mask_q) == press_mask_q);
			evt.reaction_time = {nb[5], nb[4], nb[3], nb[2]};
		end

		// saturate at both ends
		down_next = down_q;
		if (evt.pressed) begin
			if (down_q != 8'hFF) down_next = down_q + 8'd1;
		end else begin
			if (down_q != 8'h00) down_next = down_q - 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			cmd_s1  <= cmd;
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_mode_q   <= 1'b0;
			bad_port_mask_q <= 8'h00;
			press_mask_q    <= 8'h10;
			fill_q          <= '0;
			down_q          <= 8'h00;
			out_valid_q     <= 1'b0;
			for (int i = 0; i < LONG_PACKET_BYTES; i++) buf_q[i] <= 8'h00;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PACKET_MODE: begin
					packet_mode_q <= cfg_data[0];
					fill_q        <= '0;
					for (int i = 0; i < LONG_PACKET_BYTES; i++) buf_q[i] <= 8'h00;
				end
				REG_BAD_PORT_MASK: bad_port_mask_q <= cfg_data;
				REG_PRESS_MASK:    press_mask_q    <= cfg_data;
				default: ;
			endcase
		end else begin
			if (advance) begin
				out_valid_q <= 1'b0;
				if (cmd_s1 == CMD_CLEAR) begin
					down_q <= 8'h00;
				end else begin
					out_valid_q <= found;
					if (found) down_q <= down_next;
					if (flush) begin
						fill_q <= '0;
						for (int i = 0; i < LONG_PACKET_BYTES; i++) buf_q[i] <= 8'h00;
					end else begin
						fill_q <= nf_shift;
						for (int i = 0; i < LONG_PACKET_BYTES; i++) buf_q[i] <= sb[i];
					end
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (cmd_s1 == CMD_BYTE) && found) begin
			evt_q       <= evt;
			keys_down_q <= down_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign port_number   = evt_q.port_number;
	assign key_number    = evt_q.key_number;
	assign pressed       = evt_q.pressed;
	assign reaction_time = evt_q.reaction_time;
	assign keys_down     = keys_down_q;

	// the buffer never rests full
	a_fill_below_size: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < size)
		else $error("fill count reached packet size");

	// slot at the fill point is always empty
	a_slack_zero: assert property (@(posedge clk) disable iff (!arst_n)
		buf_q[fill_q[IW-1:0]] == 8'h00)
		else $error("buffer slack not zero");

	// a new result reports the count it leaves behind
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$past(advance && (cmd_s1 == CMD_BYTE) && found && !cfg_we) |->
			(out_valid && (keys_down == down_q)))
		else $error("keys_down out of step with counter");

	// a clear item leaves the counter at zero and makes no result
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (cmd_s1 == CMD_CLEAR) && !cfg_we) |=> (down_q == 8'h00) && !out_valid)
		else $error("clear item mishandled");

endmodule

// ===== bench/rpd_checker.sv =====
module rpd_checker
	import rpd_pkg::*;
#(
	parameter int LONG_PACKET_BYTES = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        cmd,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [7:0]  port_number,
	input  logic [7:0]  key_number,
	input  logic        pressed,
	input  logic [31:0] reaction_time,
	input  logic [7:0]  keys_down,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          failures,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		event_t     ev;
		logic [7:0] keys_down;
	} key_event_t;

	logic [7:0]  frame [LONG_PACKET_BYTES];
	int unsigned fill;
	logic [7:0]  down_count;
	logic        long_mode;
	logic [7:0]  bad_mask;
	logic [7:0]  press_bits;
	key_event_t  event_q [$];
	key_event_t  want;
	int          fail_count = 0;

	task automatic wipe_frame();
		for (int i = 0; i < LONG_PACKET_BYTES; i++)
			frame[i] = 8'h00;
		fill = 0;
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		int unsigned frame_len;
		int unsigned sync_at;
		logic        hit;
		key_event_t  res;
		frame_len = long_mode ? LONG_PACKET_BYTES : SHORT_PACKET_BYTES;
		sync_at   = 0;
		hit       = 1'b0;
		res       = '0;
		if (fill >= frame_len)
			wipe_frame();
		frame[fill] = b;
		fill++;
		if (!long_mode) begin
			if (frame[0] == SYNC_SHORT && (frame[1] & bad_mask) == 8'h00) begin
				if (fill == SHORT_PACKET_BYTES) begin
					res.ev.port_number   = frame[1] & PORT_MASK;
					res.ev.key_number    = (frame[1] & KEY_MASK) >> KEY_SHIFT;
					res.ev.pressed       = (frame[1] & press_bits) == press_bits;
					res.ev.reaction_time = {frame[5], frame[4], frame[3], frame[2]};
					hit = 1'b1;
				end
			end else begin
				// scan downwards so the earliest sync byte wins
				for (int i = SHORT_PACKET_BYTES - 1; i >= 1; i--)
					if (frame[i] == SYNC_SHORT)
						sync_at = i;
			end
		end else if (fill == LONG_PACKET_BYTES && frame[0] == SYNC_LONG
				&& frame[LONG_PACKET_BYTES - 1] == 8'h00) begin
			res.ev.port_number   = frame[1];
			res.ev.key_number    = frame[2];
			res.ev.pressed       = frame[3] == PRESS_CHAR;
			res.ev.reaction_time = {frame[7], frame[6], frame[5], frame[4]};
			hit = 1'b1;
		end else begin
			for (int i = LONG_PACKET_BYTES - 1; i >= 1; i--)
				if (i < fill && frame[i] == SYNC_LONG)
					sync_at = i;
		end

		if (sync_at != 0) begin
			for (int i = 0; i < LONG_PACKET_BYTES; i++)
				frame[i] = (i + sync_at < LONG_PACKET_BYTES) ? frame[i + sync_at] : 8'h00;
			fill = (fill >= sync_at) ? fill - sync_at : 0;
			for (int i = 0; i < LONG_PACKET_BYTES; i++)
				if (i >= fill)
					frame[i] = 8'h00;
		end
		if (fill >= frame_len)
			wipe_frame();

		if (hit) begin
			// saturate at both ends
			if (res.ev.pressed) begin
				if (down_count != 8'hFF)
					down_count++;
			end else if (down_count != 8'h00) begin
				down_count--;
			end
			res.keys_down = down_count;
			event_q.push_back(res);
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_frame();
			down_count = 8'h00;
			long_mode  = 1'b0;
			bad_mask   = 8'h00;
			press_bits = 8'h10;
			event_q.delete();
			pending  <= 0;
			failures <= fail_count;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PACKET_MODE: begin
						long_mode = cfg_data[0];
						wipe_frame();
					end
					REG_BAD_PORT_MASK: bad_mask = cfg_data;
					REG_PRESS_MASK: press_bits = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (cmd == CMD_CLEAR)
					down_count = 8'h00;
				else
					deframe_byte(rx_byte);
			end
			if (out_valid && !out_stall) begin
				if (event_q.size() == 0) begin
					$error("unexpected result: port %0h key %0h pressed %0b time %0h down %0h",
						port_number, key_number, pressed, reaction_time, keys_down);
					fail_count++;
				end else begin
					want = event_q.pop_front();
					check_field("port_number", want.ev.port_number, port_number);
					check_field("key_number", want.ev.key_number, key_number);
					check_field("pressed", want.ev.pressed, pressed);
					check_field("reaction_time", want.ev.reaction_time, reaction_time);
					check_field("keys_down", want.keys_down, keys_down);
				end
			end
			pending  <= event_q.size();
			failures <= fail_count;
		end
	end

endmodule

// ===== bench/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rpd_pkg::*;

	localparam int LONG_BYTES   = 9;
	localparam int QUIET_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 4;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic        cmd       = CMD_BYTE;
	logic [7:0]  rx_byte   = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  port_number;
	logic [7:0]  key_number;
	logic        pressed;
	logic [31:0] reaction_time;
	logic [7:0]  keys_down;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = REG_PACKET_MODE;
	logic [7:0]  cfg_data  = 8'h00;
	int          failures;
	int          pending;
	logic        gaps_on   = 1'b1;
	int          quiet     = 0;

	response_packet_deframer #(.LONG_PACKET_BYTES(LONG_BYTES)) dut (.*);

	rpd_checker #(.LONG_PACKET_BYTES(LONG_BYTES)) watch (.*);

	always #1 clk = ~clk;

	always @(posedge clk)
		out_stall <= gaps_on && ($urandom_range(99) < 32);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	task automatic push_item(input logic c, input logic [7:0] b);
		while (gaps_on && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		rx_byte  <= b;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic push_byte(input logic [7:0] b);
		push_item(CMD_BYTE, b);
	endtask

	task automatic push_time(input logic [31:0] t);
		push_byte(t[7:0]);
		push_byte(t[15:8]);
		push_byte(t[23:16]);
		push_byte(t[31:24]);
	endtask

	task automatic short_packet(input logic [7:0] b1, input logic [31:0] t);
		push_byte(SYNC_SHORT);
		push_byte(b1);
		push_time(t);
	endtask

	task automatic long_packet(input logic [7:0] port, input logic [7:0] key,
			input logic [7:0] flag, input logic [31:0] t, input logic [7:0] tail);
		push_byte(SYNC_LONG);
		push_byte(port);
		push_byte(key);
		push_byte(flag);
		push_time(t);
		push_byte(tail);
	endtask

	// broken frame, lone byte or counter clear
	task automatic stray(input logic [7:0] sync);
		int cut;
		cut = $urandom_range(1, (sync == SYNC_LONG) ? LONG_BYTES - 1 : SHORT_PACKET_BYTES - 1);
		case ($urandom_range(2))
			0: begin
				push_byte(sync);
				for (int i = 1; i < cut; i++)
					push_byte(8'($urandom));
			end
			1: push_byte(8'($urandom));
			default: push_item(CMD_CLEAR, 8'($urandom));
		endcase
	endtask

	// drop valid, drain every pending result, then let in-flight items retire
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(input logic mode, input logic [7:0] bad, input logic [7:0] press);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_PACKET_MODE;
		cfg_data  <= {7'd0, mode};
		@(posedge clk);
		cfg_index <= REG_BAD_PORT_MASK;
		cfg_data  <= bad;
		@(posedge clk);
		cfg_index <= REG_PRESS_MASK;
		cfg_data  <= press;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	initial begin
		logic [7:0] b1;
		logic [7:0] bad;
		logic [7:0] press;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register defaults: short frames, press on bit 4
		short_packet(8'hFF, 32'hFFFF_FFFF);
		short_packet(8'h00, 32'h0000_0000);
		short_packet(8'h0F, 32'h1234_5678);
		push_item(CMD_CLEAR, 8'hFF);
		// a clear inside a frame leaves the frame intact
		push_byte(SYNC_SHORT);
		push_byte(8'h10);
		push_item(CMD_CLEAR, 8'h00);
		push_time(32'h8000_0001);
		// junk ahead of the sync byte: resync onto it
		push_byte(8'h00);
		push_byte(SYNC_SHORT);
		push_byte(8'hB3);
		push_time(32'hA5A5_5A5A);
		// no sync at all: the buffer fills and is dropped
		push_byte(8'h00);
		push_byte(8'h55);
		push_byte(8'hAA);
		push_byte(8'h80);
		push_byte(8'h7F);
		push_byte(8'hFF);
		short_packet(8'h30, 32'h0000_00FF);
		// partial frame, then a mode change throws it away
		push_byte(SYNC_SHORT);
		push_byte(8'h10);
		push_byte(8'h01);
		set_regs(1'b1, 8'hFF, 8'hFF);
		long_packet(8'hFF, 8'hFF, PRESS_CHAR, 32'hFFFF_FFFF, 8'h00);
		long_packet(8'h00, 8'h00, 8'h30, 32'h0000_0000, 8'h00);
		long_packet(8'h01, 8'h02, PRESS_CHAR, 32'h0102_0304, 8'h01);
		push_byte(SYNC_LONG);
		push_byte(SYNC_LONG);
		push_byte(8'h05);

		// every header valid and every event a press: climb to the ceiling
		set_regs(1'b0, 8'h00, 8'h00);
		gaps_on <= 1'b0;
		for (int n = 0; n < 262; n++) begin
			if (n == 100)
				gaps_on <= 1'b1;
			short_packet(8'($urandom), $urandom);
		end

		for (int s = 0; s < 4; s++) begin
			bad   = (s == 0) ? 8'hFF : (s == 1) ? 8'h00 : 8'($urandom);
			press = (s < 2) ? 8'hFF : 8'($urandom);
			set_regs(1'b0, bad, press);
			for (int n = 0; n < 7; n++) begin
				if ($urandom_range(99) < 20) begin
					stray(SYNC_SHORT);
				end else begin
					b1 = 8'($urandom);
					if ($urandom_range(99) < 50)
						b1 = b1 | press;
					if ($urandom_range(99) < 80)
						b1 = b1 & ~bad;
					short_packet(b1, $urandom);
				end
			end
		end

		for (int s = 0; s < 2; s++) begin
			set_regs(1'b1, 8'($urandom), 8'($urandom));
			for (int n = 0; n < 7; n++) begin
				if ($urandom_range(99) < 20)
					stray(SYNC_LONG);
				else
					long_packet(8'($urandom), 8'($urandom),
						($urandom_range(1) != 0) ? PRESS_CHAR : 8'($urandom),
						$urandom, ($urandom_range(9) == 0) ? 8'($urandom) : 8'h00);
			end
		end

		settle();
		if (failures == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
